>>> rtl/core/pkhm_pkg.sv
package pkhm_pkg;

  localparam int TableSlotsDef = 1024;

  localparam logic [63:0] MixAdd  = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MixMul1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MixMul2 = 64'h94d049bb133111eb;
  localparam int MixSh1 = 30;
  localparam int MixSh2 = 27;
  localparam int MixSh3 = 31;
  localparam int LoadNum = 7;
  localparam int LoadDen = 10;

  typedef enum logic [1:0] {
    FN_PUT   = 2'd0,
    FN_GET   = 2'd1,
    FN_CLEAR = 2'd2,
    FN_NONE  = 2'd3
  } func_t;

  typedef struct packed {
    func_t              func;
    logic [30:0]        key_first;
    logic [30:0]        key_second;
    logic signed [31:0] write_value;
  } op_t;

  typedef enum logic [2:0] {
    F_IDLE, F_M1, F_S1, F_M2, F_S2, F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_RD, B_CHK, B_CLR, B_DONE
  } back_state_t;

endpackage

>>> rtl/core/pkhm_intf.sv
interface pkhm_in_if;
  import pkhm_pkg::*;
  logic               valid;
  logic               ready;
  func_t              func;
  logic [30:0]        key_first;
  logic [30:0]        key_second;
  logic signed [31:0] write_value;
  modport source (output valid, func, key_first, key_second, write_value, input ready);
  modport sink (input valid, func, key_first, key_second, write_value, output ready);
endinterface

interface pkhm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] read_value;
  logic               found;
  logic               status;
  modport source (output valid, read_value, found, status, input ready);
  modport sink (input valid, read_value, found, status, output ready);
endinterface

>>> rtl/core/pkhm_front.sv
module pkhm_front import pkhm_pkg::*; #(
  parameter int AW = $clog2(TableSlotsDef)
) (
  input  logic              clk,
  input  logic              rst_n,
  pkhm_in_if.sink           in_ch,
  output logic              push_valid,
  input  logic              push_ready,
  output logic [AW-1:0]     push_home,
  output op_t               push_op
);

  front_state_t state_r, state_nxt;
  op_t          op_r;
  logic [63:0]  z_r;
  logic [63:0]  p0_r;
  logic [31:0]  p1_r, p2_r;
  logic [63:0]  x, cm, fin;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: if (in_ch.valid) state_nxt = F_M1;
      F_M1:   state_nxt = F_S1;
      F_S1:   state_nxt = F_M2;
      F_M2:   state_nxt = F_S2;
      F_S2:   state_nxt = F_PUSH;
      F_PUSH: if (push_ready) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = (state_r == F_IDLE);
    push_valid  = (state_r == F_PUSH);
    if (state_r == F_M1) begin
      x  = z_r ^ (z_r >> MixSh1);
      cm = MixMul1;
    end else begin
      x  = z_r ^ (z_r >> MixSh2);
      cm = MixMul2;
    end
    fin       = z_r ^ (z_r >> MixSh3);
    push_home = fin[AW-1:0];
    push_op   = op_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // 64x64 low product split into three 32x32 partials
  always_ff @(posedge clk) begin
    unique case (state_r)
      F_IDLE: begin
        if (in_ch.valid) begin
          op_r.func        <= in_ch.func;
          op_r.key_first   <= in_ch.key_first;
          op_r.key_second  <= in_ch.key_second;
          op_r.write_value <= in_ch.write_value;
          z_r <= {1'b0, in_ch.key_first, 1'b0, in_ch.key_second} + MixAdd;
        end
      end
      F_M1, F_M2: begin
        p0_r <= x[31:0] * cm[31:0];
        p1_r <= 32'(x[31:0] * cm[63:32]);
        p2_r <= 32'(x[63:32] * cm[31:0]);
      end
      F_S1, F_S2: begin
        z_r <= p0_r + {p1_r + p2_r, 32'd0};
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/core/pkhm_queue.sv
module pkhm_queue #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  logic [DW-1:0] push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output logic [DW-1:0] pop_data
);

  logic [DW-1:0] mem_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  logic          do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = mem_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push_data;
  end

endmodule

>>> rtl/core/pkhm_back.sv
module pkhm_back import pkhm_pkg::*; #(
  parameter int TABLE_SLOTS = TableSlotsDef,
  parameter int AW = $clog2(TABLE_SLOTS)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  logic [AW-1:0] pop_home,
  input  op_t           pop_op,
  pkhm_out_if.source    out_ch
);

  localparam int CW = AW + 1;
  localparam int LoadLimit = TABLE_SLOTS * LoadNum / LoadDen;

  back_state_t state_r, state_nxt;
  op_t         cur_r;
  logic [AW-1:0] pos_r, n_r, clr_r;
  logic [CW-1:0] cnt_r;
  logic          clr_reply_r;
  logic signed [31:0] res_rv_r;
  logic          res_fnd_r, res_st_r;
  logic          out_valid_r, out_fnd_r, out_st_r;
  logic signed [31:0] out_rv_r;

  logic [61:0] key_mem [TABLE_SLOTS];
  logic [31:0] val_mem [TABLE_SLOTS];
  logic [61:0] rd_key_r;
  logic [31:0] rd_val_r;

  logic [61:0] cur_key;
  logic        key_zero, slot_empty, slot_hit, probe_end, at_limit, res_ok;
  logic        key_we, val_we;
  logic [AW-1:0] wa;
  logic [61:0] wk;

  assign cur_key    = {cur_r.key_first, cur_r.key_second};
  assign key_zero   = ({pop_op.key_first, pop_op.key_second} == 62'd0);
  assign slot_empty = (rd_key_r == 62'd0);
  assign slot_hit   = (rd_key_r == cur_key);
  assign probe_end  = (n_r == {AW{1'b1}});
  assign at_limit   = (cnt_r >= CW'(LoadLimit));
  assign res_ok     = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (pop_valid) begin
          if (pop_op.func == FN_CLEAR) state_nxt = B_CLR;
          else if ((pop_op.func == FN_PUT || pop_op.func == FN_GET) && !key_zero)
            state_nxt = B_RD;
          else state_nxt = B_DONE;
        end
      end
      B_RD:  state_nxt = B_CHK;
      B_CHK: begin
        if (slot_empty || slot_hit || probe_end) state_nxt = B_DONE;
        else state_nxt = B_RD;
      end
      B_CLR: begin
        if (clr_r == {AW{1'b1}}) state_nxt = clr_reply_r ? B_DONE : B_IDLE;
      end
      B_DONE: if (res_ok) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    pop_ready = (state_r == B_IDLE);
    key_we    = 1'b0;
    val_we    = 1'b0;
    wa        = pos_r;
    wk        = cur_key;
    if (state_r == B_CLR) begin
      key_we = 1'b1;
      wa     = clr_r;
      wk     = 62'd0;
    end else if (state_r == B_CHK && cur_r.func == FN_PUT) begin
      if (slot_hit) begin
        val_we = 1'b1;
      end else if (slot_empty && !at_limit) begin
        key_we = 1'b1;
        val_we = 1'b1;
      end
    end
    out_ch.valid      = out_valid_r;
    out_ch.read_value = out_rv_r;
    out_ch.found      = out_fnd_r;
    out_ch.status     = out_st_r;
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[wa] <= wk;
    if (val_we) val_mem[wa] <= cur_r.write_value;
    rd_key_r <= key_mem[pos_r];
    rd_val_r <= val_mem[pos_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLR;
      clr_r       <= '0;
      clr_reply_r <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // a new result may replace the one taken in the same cycle
      if (state_r == B_DONE && res_ok) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        B_IDLE: begin
          clr_r       <= '0;
          clr_reply_r <= 1'b1;
        end
        B_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == {AW{1'b1}}) cnt_r <= '0;
        end
        B_CHK: begin
          if (key_we) cnt_r <= cnt_r + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        cur_r     <= pop_op;
        pos_r     <= pop_home;
        n_r       <= '0;
        res_rv_r  <= '0;
        res_fnd_r <= 1'b0;
        res_st_r  <= 1'b0;
      end
      B_CHK: begin
        if (slot_hit) begin
          res_fnd_r <= 1'b1;
          if (cur_r.func == FN_GET) res_rv_r <= rd_val_r;
        end else if (slot_empty) begin
          if (cur_r.func == FN_PUT && at_limit) res_st_r <= 1'b1;
        end else if (probe_end) begin
          if (cur_r.func == FN_PUT) res_st_r <= 1'b1;
        end else begin
          pos_r <= pos_r + 1'b1;
          n_r   <= n_r + 1'b1;
        end
      end
      B_DONE: begin
        if (res_ok) begin
          out_rv_r  <= res_rv_r;
          out_fnd_r <= res_fnd_r;
          out_st_r  <= res_st_r;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/core/pair_key_hash_map.sv
// flow: an accepted transaction passes the hash front and the queue to the probe
// engine, which reads and checks one probed slot at a time and then registers
// the result
// intake: the hash front holds one transaction through its multiply stages and
// takes no new one until it has pushed it on; long probe walks stall it
// reset: a clearing pass over all TABLE_SLOTS slots empties the table before the
// first transaction is probed; a clear transaction takes the same pass
module pair_key_hash_map import pkhm_pkg::*; #(
  parameter int TABLE_SLOTS = TableSlotsDef
) (
  input  logic       clk,
  input  logic       rst_n,
  pkhm_in_if.sink    in_ch,
  pkhm_out_if.source out_ch
);

  localparam int AW = $clog2(TABLE_SLOTS);
  localparam int DW = AW + $bits(op_t);

  // front to queue
  logic          f_valid, f_ready;
  logic [AW-1:0] f_home;
  op_t           f_op;

  // queue to back
  logic          q_valid, q_ready;
  logic [DW-1:0] q_data;
  logic [AW-1:0] q_home;
  op_t           q_op;

  // hashing front: splitmix64 over the joined key
  pkhm_front #(.AW(AW)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_home  (f_home),
    .push_op    (f_op)
  );

  // short queue decouples hashing from probing
  pkhm_queue #(.DW(DW)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  ({f_home, f_op}),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  assign q_home = q_data[DW-1 -: AW];
  assign q_op   = op_t'(q_data[$bits(op_t)-1:0]);

  // probe engine with slot memories and result register
  pkhm_back #(.TABLE_SLOTS(TABLE_SLOTS), .AW(AW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_home  (q_home),
    .pop_op    (q_op),
    .out_ch    (out_ch)
  );

endmodule

>>> sim/pair_key_hash_map_checker.sv
module pair_key_hash_map_checker import pkhm_pkg::*; #(
  parameter int TABLE_SLOTS = TableSlotsDef
) (
  input  logic  clk,
  input  logic  rst_n,
  pkhm_in_if    in_ch,
  pkhm_out_if   out_ch,
  output int    fail_count,
  output int    pending_count
);

  typedef struct packed {
    logic signed [31:0] read_value;
    logic               found;
    logic               status;
  } answer_t;

  logic [63:0]        shadow_key [TABLE_SLOTS];
  logic signed [31:0] shadow_val [TABLE_SLOTS];
  int unsigned        shadow_count;
  answer_t            answer_q[$];

  function automatic logic [63:0] splitmix(input logic [63:0] k);
    logic [63:0] z;
    z = k + MixAdd;
    z = (z ^ (z >> MixSh1)) * MixMul1;
    z = (z ^ (z >> MixSh2)) * MixMul2;
    return z ^ (z >> MixSh3);
  endfunction

  // walks the shadow table and applies one transaction
  function automatic answer_t apply_op(input func_t fn, input logic [30:0] kf,
                                       input logic [30:0] ks,
                                       input logic signed [31:0] wv);
    answer_t     a;
    logic [63:0] key;
    int          pos;
    int          slot;
    bit          hit;
    bit          ok;
    a = '0;
    key = {1'b0, kf, 1'b0, ks};
    ok = 0;
    hit = 0;
    slot = 0;
    if (fn == FN_CLEAR) begin
      for (int i = 0; i < TABLE_SLOTS; i++) shadow_key[i] = '0;
      shadow_count = 0;
      return a;
    end
    if (fn == FN_NONE || key == 0) return a;
    pos = int'(splitmix(key) & 64'(TABLE_SLOTS - 1));
    for (int n = 0; n < TABLE_SLOTS; n++) begin
      if (shadow_key[pos] == 0 || shadow_key[pos] == key) begin
        ok = 1;
        hit = (shadow_key[pos] == key);
        slot = pos;
        break;
      end
      pos = (pos + 1) & (TABLE_SLOTS - 1);
    end
    if (fn == FN_GET) begin
      if (ok && hit) begin
        a.read_value = shadow_val[slot];
        a.found = 1;
      end
    end else if (!ok) begin
      a.status = 1;
    end else if (hit) begin
      shadow_val[slot] = wv;
      a.found = 1;
    end else if ((shadow_count + 1) * LoadDen > TABLE_SLOTS * LoadNum) begin
      a.status = 1;
    end else begin
      shadow_key[slot] = key;
      shadow_val[slot] = wv;
      shadow_count++;
    end
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_SLOTS; i++) shadow_key[i] = '0;
      shadow_count = 0;
      answer_q.delete();
      fail_count = 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        answer_q.push_back(apply_op(in_ch.func, in_ch.key_first, in_ch.key_second,
                                    in_ch.write_value));
      if (out_ch.valid && out_ch.ready) begin
        if (answer_q.size() == 0) begin
          $error("result with nothing expected");
          fail_count++;
        end else begin
          want = answer_q.pop_front();
          if (out_ch.read_value !== want.read_value) begin
            $error("read_value expected %0d actual %0d", want.read_value,
                   out_ch.read_value);
            fail_count++;
          end
          if (out_ch.found !== want.found) begin
            $error("found expected %0b actual %0b", want.found, out_ch.found);
            fail_count++;
          end
          if (out_ch.status !== want.status) begin
            $error("status expected %0b actual %0b", want.status, out_ch.status);
            fail_count++;
          end
        end
      end
    end
    pending_count = answer_q.size();
  end

endmodule

>>> sim/pair_key_hash_map_tb.sv
module pair_key_hash_map_tb;
  import pkhm_pkg::*;

  localparam int Slots      = TableSlotsDef;
  // clearing pass plus a full probe walk, with margin
  localparam int StallLimit = 40 * Slots + 2000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_count;
  int   quiet_cycles;
  bit   calm;           // no idling in the last part of the run
  bit   hold_sink;      // long receiver hold-off to fill the block
  int   sink_gap;

  pkhm_in_if  in_ch();
  pkhm_out_if out_ch();

  pair_key_hash_map #(.TABLE_SLOTS(Slots)) DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  pair_key_hash_map_checker #(.TABLE_SLOTS(Slots)) u_checker (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // keys reused across puts and gets so that hits are common
  logic [30:0] pool_first [64];
  logic [30:0] pool_second [64];

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // receiver: random stall bursts, one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 0;
      sink_gap <= 0;
    end else if (hold_sink) begin
      out_ch.ready <= 0;
    end else if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      out_ch.ready <= 0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      sink_gap <= $urandom_range(0, 5);
      out_ch.ready <= 0;
    end else begin
      out_ch.ready <= 1;
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > StallLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // offer one transaction and hold it until accepted
  task automatic send_op(input func_t fn, input logic [30:0] kf, input logic [30:0] ks,
                         input logic signed [31:0] wv);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.func <= fn;
    in_ch.key_first <= kf;
    in_ch.key_second <= ks;
    in_ch.write_value <= wv;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic random_op();
    int          pick;
    int          r;
    logic [30:0] kf;
    logic [30:0] ks;
    func_t       fn;
    pick = $urandom_range(0, 63);
    r = $urandom_range(0, 99);
    if (r < 70) begin
      kf = pool_first[pick];
      ks = pool_second[pick];
    end else begin
      kf = 31'($urandom);
      ks = 31'($urandom);
    end
    r = $urandom_range(0, 199);
    if (r == 0) fn = FN_CLEAR;
    else if (r == 1) fn = FN_NONE;
    else if (r < 100) fn = FN_PUT;
    else fn = FN_GET;
    send_op(fn, kf, ks, $signed($urandom));
  endtask

  initial begin
    int k;
    rst_n = 0;
    calm = 0;
    hold_sink = 0;
    in_ch.valid = 0;
    in_ch.func = FN_PUT;
    in_ch.key_first = '0;
    in_ch.key_second = '0;
    in_ch.write_value = '0;
    for (int i = 0; i < 64; i++) begin
      pool_first[i] = 31'($urandom);
      pool_second[i] = 31'($urandom);
    end
    repeat (5) @(posedge clk);
    rst_n <= 1;

    // directed: extremes, every operation, zero key, overwrite, clear, unused code
    send_op(FN_GET, '1, '1, 0);
    send_op(FN_PUT, '1, '1, 32'sh7fffffff);
    send_op(FN_GET, '1, '1, 0);
    send_op(FN_PUT, '1, '1, 32'sh80000000);
    send_op(FN_GET, '1, '1, 0);
    send_op(FN_PUT, 0, 0, -1);
    send_op(FN_GET, 0, 0, 0);
    send_op(FN_PUT, 0, 1, -1);
    send_op(FN_PUT, 1, 0, 1);
    send_op(FN_GET, 0, 1, 0);
    send_op(FN_GET, 1, 0, 0);
    send_op(FN_NONE, '1, '1, -1);
    send_op(FN_GET, '1, '1, 0);
    send_op(FN_CLEAR, 0, 0, 0);
    send_op(FN_GET, '1, '1, 0);
    send_op(FN_GET, 0, 1, 0);

    // load limit: fill past 70 percent with distinct keys, then overwrite and probe
    for (int i = 0; i < Slots * 7 / 10 + 8; i++) send_op(FN_PUT, 31'(i + 1), 31'(i * 3), i);
    send_op(FN_PUT, 31'(1), 31'(0), -7);
    send_op(FN_GET, 31'(1), 31'(0), 0);
    send_op(FN_GET, '1, 31'(5), 0);
    for (int i = 0; i < 300; i++) random_op();
    send_op(FN_CLEAR, 0, 0, 0);

    // long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_sink = 1;
        repeat (200) @(posedge clk);
        hold_sink = 0;
      end
      for (int i = 0; i < 30; i++) random_op();
    join

    for (int i = 0; i < 330; i++) random_op();
    calm = 1;
    for (int i = 0; i < 200; i++) random_op();
    in_ch.valid <= 0;

    k = 0;
    while (pending_count != 0 && k < StallLimit) begin
      @(posedge clk);
      k++;
    end
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

>>> files.f
rtl/core/pkhm_pkg.sv
rtl/core/pkhm_intf.sv
rtl/core/pkhm_front.sv
rtl/core/pkhm_queue.sv
rtl/core/pkhm_back.sv
rtl/core/pair_key_hash_map.sv
sim/pair_key_hash_map_checker.sv
sim/pair_key_hash_map_tb.sv
